/* design/matrix_multiply_engine_assert.svh */
// ----------------------------------------------------------------------------
// Matrix multiply engine assertion macros
// Shorthand for the concurrent checks used by the engine's modules.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define MME_ASSERT_COMB(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/mme_pkg.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Widths, command and register codes, sequencer states and the MAC op type.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam int DEFAULT_MAX_DIM = 8;

   localparam int DIM_W      = 4;
   localparam int IDX_W      = 3;
   localparam int ELEM_W     = 32;
   localparam int PROD_W     = 64;
   localparam int ACC_W      = PROD_W + DIM_W;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(8);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_RUN     = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROWS  = 2'd0,
      REG_INNER = 2'd1,
      REG_COLS  = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT_OUT,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic zero;
   } mac_op_type;

endpackage

/* design/mme_ram.sv */
// ----------------------------------------------------------------------------
// Matrix element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram
   import mme_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_DIM * DEFAULT_MAX_DIM,
   parameter int AW    = $clog2(DEFAULT_MAX_DIM * DEFAULT_MAX_DIM)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [ELEM_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [ELEM_W-1:0] rd_data
);

   logic [ELEM_W-1:0] mem [DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mme_mac.sv */
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Shared 32x32 multiplier and wide accumulator; saturates the final sum.
// ----------------------------------------------------------------------------
module mme_mac
   import mme_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_op_type               op,
   input  logic signed [ELEM_W-1:0] a_data,
   input  logic signed [ELEM_W-1:0] b_data,
   output logic                     done,
   output logic        [PROD_W-1:0] sum
);

   mac_op_type               op1_ff;
   mac_op_type               op2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     done_ff;
   logic                     done_in;
   logic                     in_range;

   // op1 lines up with the registered store read data
   always_ff @(posedge clock) begin
      if (reset) begin
         op1_ff  <= '0;
         op2_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         op1_ff  <= op;
         op2_ff  <= op1_ff;
         done_ff <= done_in;
      end
   end

   // signed product, kept apart from the unsigned zero
   always_comb begin
      if (op1_ff.zero) begin
         prod_in = '0;
      end else begin
         prod_in = a_data * b_data;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      acc_in  = acc_ff;
      done_in = op2_ff.valid && op2_ff.last;
      if (op2_ff.valid) begin
         if (op2_ff.first) begin
            acc_in = ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   always_comb begin
      in_range = (&acc_ff[ACC_W-1:PROD_W-1]) || (~|acc_ff[ACC_W-1:PROD_W-1]);
      if (in_range) begin
         sum = acc_ff[PROD_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sum = {1'b1, {(PROD_W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(PROD_W-1){1'b1}}};
      end
   end

   assign done = done_ff;

endmodule

/* design/mme_ctrl.sv */
// ----------------------------------------------------------------------------
// Matrix multiply sequencer
// Decodes load and run items, walks row, column and inner indexes.
// ----------------------------------------------------------------------------
module mme_ctrl
   import mme_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM,
   parameter int AW      = $clog2(DEFAULT_MAX_DIM * DEFAULT_MAX_DIM)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cmd_type          req_cmd,
   input  logic [IDX_W-1:0] req_row,
   input  logic [IDX_W-1:0] req_col,
   input  logic [DIM_W-1:0] rows_of_a,
   input  logic [DIM_W-1:0] inner_size,
   input  logic [DIM_W-1:0] cols_of_b,
   input  logic             rsp_free,
   input  logic             mac_done,
   output logic             a_we,
   output logic             b_we,
   output logic [AW-1:0]    wr_addr,
   output logic [AW-1:0]    rd_addr_a,
   output logic [AW-1:0]    rd_addr_b,
   output mac_op_type       op,
   output logic [IDX_W-1:0] out_row,
   output logic [IDX_W-1:0] out_col,
   output logic             out_last
);

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] i_ff, i_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [DIM_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] nr_ff, nr_in;
   logic [DIM_W-1:0] nk_ff, nk_in;
   logic [DIM_W-1:0] nc_ff, nc_in;
   logic [DIM_W-1:0] nr_eff, nk_eff, nc_eff;
   logic             accept;
   logic             wr_ok;
   logic             last_k;
   logic             row_last;
   logic             col_last;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      nr_ff <= nr_in;
      nk_ff <= nk_in;
      nc_ff <= nc_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_ok     = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
   assign wr_addr   = AW'(32'(req_row) * MAX_DIM + 32'(req_col));
   assign rd_addr_a = AW'(32'(i_ff) * MAX_DIM + 32'(k_ff));
   assign rd_addr_b = AW'(32'(k_ff) * MAX_DIM + 32'(j_ff));
   assign nr_eff    = clamp_dim(rows_of_a);
   assign nk_eff    = clamp_dim(inner_size);
   assign nc_eff    = clamp_dim(cols_of_b);
   assign last_k    = (nk_ff == '0) || (k_ff == nk_ff - DIM_W'(1));
   assign row_last  = (i_ff == nr_ff - DIM_W'(1));
   assign col_last  = (j_ff == nc_ff - DIM_W'(1));
   assign out_row   = i_ff[IDX_W-1:0];
   assign out_col   = j_ff[IDX_W-1:0];
   assign out_last  = row_last && col_last;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      nr_in    = nr_ff;
      nk_in    = nk_ff;
      nc_in    = nc_ff;
      a_we     = 1'b0;
      b_we     = 1'b0;
      op       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_WRITE_A: begin
                     a_we = wr_ok;
                  end
                  CMD_WRITE_B: begin
                     b_we = wr_ok;
                  end
                  CMD_RUN: begin
                     if (nr_eff != '0 && nc_eff != '0) begin
                        nr_in    = nr_eff;
                        nk_in    = nk_eff;
                        nc_in    = nc_eff;
                        i_in     = '0;
                        j_in     = '0;
                        k_in     = '0;
                        state_in = ST_WAIT_OUT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WAIT_OUT: begin
            if (rsp_free) begin
               k_in     = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            op.valid = 1'b1;
            op.first = (k_ff == '0);
            op.last  = last_k;
            op.zero  = (nk_ff == '0);
            if (last_k) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               if (row_last && col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WAIT_OUT;
                  if (col_last) begin
                     j_in = '0;
                     i_in = i_ff + DIM_W'(1);
                  end else begin
                     j_in = j_ff + DIM_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/matrix_multiply_engine.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Loads A and B element by element, then streams out every element of A*B.
//
// req_*  : input items. tuser = command (write A, write B, run).
//          Load items are taken one per cycle while the engine is idle and give no output item.
// rsp_*  : one item per product element, row-major; tlast on the final one.
// csr_*  : register writes (rows_of_a, inner_size, cols_of_b), always ready;
//          write only while the engine is idle.
// Timing: a run walks the products through one shared 32x32 multiplier and a
//   68-bit accumulator, one inner term per cycle. Each product element takes
//   a start step that waits for a free output register, one issue per inner
//   term (at least one), then a drain through the read, multiply and
//   accumulate stages. req_tready is low for the run.
// Reset: clears control state and sets the size registers to 8. Store
//   contents are undefined until written.
// Backpressure: a held rsp item stops the next product from starting;
//   nothing is dropped.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_assert.svh"

module matrix_multiply_engine
   import mme_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] row_index, [5:3] col_index, [37:6] element_value, [39:38] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] out_row, [5:3] out_col, [69:6] product_value, [71:70] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DIM_W-1:0]  rows_ff, rows_in;
   logic [DIM_W-1:0]  inner_ff, inner_in;
   logic [DIM_W-1:0]  cols_ff, cols_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [PROD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_free;
   logic              a_we, b_we;
   logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
   logic [ELEM_W-1:0] a_rd, b_rd;
   mac_op_type        op;
   logic              mac_done;
   logic [PROD_W-1:0] mac_sum;
   logic [IDX_W-1:0]  cur_row, cur_col;
   logic              cur_last;

   // register file
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= RESET_DIM;
         inner_ff <= RESET_DIM;
         cols_ff  <= RESET_DIM;
      end else begin
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
      end
   end

   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_valid) begin
         unique case (reg_type'(csr_index))
            REG_ROWS:  rows_in  = csr_data;
            REG_INNER: inner_in = csr_data;
            REG_COLS:  cols_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   mme_ctrl #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (cmd_type'(req_tuser)),
      .req_row    (req_tdata[2:0]),
      .req_col    (req_tdata[5:3]),
      .rows_of_a  (rows_ff),
      .inner_size (inner_ff),
      .cols_of_b  (cols_ff),
      .rsp_free   (rsp_free),
      .mac_done   (mac_done),
      .a_we       (a_we),
      .b_we       (b_we),
      .wr_addr    (wr_addr),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .op         (op),
      .out_row    (cur_row),
      .out_col    (cur_col),
      .out_last   (cur_last)
   );

   mme_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[37:6]),
      .rd_addr (rd_addr_a),
      .rd_data (a_rd)
   );

   mme_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[37:6]),
      .rd_addr (rd_addr_b),
      .rd_data (b_rd)
   );

   mme_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .a_data (a_rd),
      .b_data (b_rd),
      .done   (mac_done),
      .sum    (mac_sum)
   );

   // output register
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (mac_done) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = cur_row;
         rsp_col_in   = cur_col;
         rsp_value_in = mac_sum;
         rsp_last_in  = cur_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_value_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

   `MME_ASSERT_COMB(a_done_into_free, clock, reset, mac_done,
      !rsp_valid_ff || rsp_tready, "MAC result arrived while output item still held")
   `MME_ASSERT_COMB(a_last_quiet, clock, reset, rsp_valid_ff && rsp_last_ff,
      !mac_done, "MAC result arrived behind the last item of a run")
   `MME_ASSERT_NEXT(a_run_busy, clock, reset,
      req_tvalid && req_tready && req_tuser == CMD_RUN && rows_ff != '0 && cols_ff != '0,
      !req_tready, "engine ready in the cycle after a run was accepted")

endmodule

/* bench/tb_matrix_multiply_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply engine testbench
// Loads A and B over the req stream and issues run commands under several size
// settings. Each accepted write item updates the local copy of its matrix. A run
// item queues every product element of A*B: the exact sum of signed Q64.0 terms,
// saturated to 64 bits. Each rsp item is checked field by field against the
// oldest queued element. Both sides stall at random, and one long rsp hold
// backs the engine up into its input.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine;
   import mme_pkg::*;

   localparam int MAX_DIM       = DEFAULT_MAX_DIM;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 150;
   localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
   localparam logic signed [71:0] SUM_MAX   = 72'sh00_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [71:0] SUM_MIN   = 72'shFF_8000_0000_0000_0000;

   typedef struct {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [PROD_W-1:0] value;
      logic              last;
   } product_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [DIM_W-1:0]      csr_data;

   logic [ELEM_W-1:0] a_mat   [MAX_DIM][MAX_DIM];
   logic [ELEM_W-1:0] b_mat   [MAX_DIM][MAX_DIM];
   bit                a_known [MAX_DIM][MAX_DIM];
   bit                b_known [MAX_DIM][MAX_DIM];
   logic [DIM_W-1:0]  cfg_rows;
   logic [DIM_W-1:0]  cfg_inner;
   logic [DIM_W-1:0]  cfg_cols;

   product_type pending_products[$];
   int          error_count;
   int          accepted_items;
   int          req_gap_max;
   int          rsp_stall_max;
   int          rsp_hold_cycles;

   matrix_multiply_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR %s", $time, msg);
      error_count++;
   endtask

   function automatic int eff_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : int'(v);
   endfunction

   function automatic logic [PROD_W-1:0] dot_row_col(input int i, input int j, input int nk);
      logic signed [71:0]       acc;
      logic signed [PROD_W-1:0] term;
      acc = '0;
      for (int k = 0; k < nk; k++) begin
         term = $signed(a_mat[i][k]) * $signed(b_mat[k][j]);
         acc  = acc + term;
      end
      if (acc > SUM_MAX) return SUM_MAX[PROD_W-1:0];
      if (acc < SUM_MIN) return SUM_MIN[PROD_W-1:0];
      return acc[PROD_W-1:0];
   endfunction

   // Store update and product prediction for one accepted item.
   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] value);
      int          nr;
      int          nk;
      int          nc;
      product_type p;
      case (cmd)
         CMD_WRITE_A: begin
            a_mat[row][col]   = value;
            a_known[row][col] = 1'b1;
         end
         CMD_WRITE_B: begin
            b_mat[row][col]   = value;
            b_known[row][col] = 1'b1;
         end
         CMD_RUN: begin
            nr = eff_dim(cfg_rows);
            nk = eff_dim(cfg_inner);
            nc = eff_dim(cfg_cols);
            for (int i = 0; i < nr; i++) begin
               for (int j = 0; j < nc; j++) begin
                  p.row   = IDX_W'(i);
                  p.col   = IDX_W'(j);
                  p.value = dot_row_col(i, j, nk);
                  p.last  = (i == nr - 1) && (j == nc - 1);
                  pending_products.push_back(p);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] value);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, value, col, row};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      apply_command(cmd, row, col, value);
      if (cmd != CMD_UNUSED) accepted_items++;
   endtask

   task automatic send_run();
      send_item(CMD_RUN, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)), $urandom);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_type idx, input logic [DIM_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ROWS:  cfg_rows  = val;
         REG_INNER: cfg_inner = val;
         REG_COLS:  cfg_cols  = val;
         default: ;
      endcase
   endtask

   task automatic write_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                             input logic [DIM_W-1:0] cols);
      wait_drained();
      write_reg(REG_ROWS, rows);
      write_reg(REG_INNER, inner);
      write_reg(REG_COLS, cols);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ELEM_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return ELEM_W'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] rand_dim();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return DIM_W'($urandom_range(1, 4));
      if (pick < 9) return DIM_W'($urandom_range(5, 8));
      pick = $urandom_range(8, 15);
      return (pick == 8) ? '0 : DIM_W'(pick);
   endfunction

   function automatic logic [CMD_W-1:0] CMD_CMD_SEL();
      return $urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A;
   endfunction

   // Loads every entry the next run reads that has not been written yet.
   task automatic ensure_loaded();
      int nr;
      int nk;
      int nc;
      nr = eff_dim(cfg_rows);
      nk = eff_dim(cfg_inner);
      nc = eff_dim(cfg_cols);
      for (int i = 0; i < nr; i++)
         for (int k = 0; k < nk; k++)
            if (!a_known[i][k]) send_item(CMD_WRITE_A, IDX_W'(i), IDX_W'(k), rand_value());
      for (int k = 0; k < nk; k++)
         for (int j = 0; j < nc; j++)
            if (!b_known[k][j]) send_item(CMD_WRITE_B, IDX_W'(k), IDX_W'(j), rand_value());
   endtask

   task automatic test_single_element();
      write_dims(1, 1, 1);
      send_item(CMD_WRITE_A, 0, 0, 32'h7FFF_FFFF);
      send_item(CMD_WRITE_B, 0, 0, 32'h8000_0000);
      send_run();
      send_item(CMD_WRITE_A, 0, 0, 32'h8000_0000);
      send_item(CMD_WRITE_B, 0, 0, 32'h8000_0000);
      send_run();
   endtask

   // Three extreme terms push the sum past either end of the 64-bit range.
   task automatic test_saturation();
      write_dims(1, 3, 1);
      for (int k = 0; k < 3; k++) send_item(CMD_WRITE_A, 0, IDX_W'(k), 32'h8000_0000);
      for (int k = 0; k < 3; k++) send_item(CMD_WRITE_B, IDX_W'(k), 0, 32'h8000_0000);
      send_run();
      for (int k = 0; k < 3; k++) send_item(CMD_WRITE_B, IDX_W'(k), 0, 32'h7FFF_FFFF);
      send_run();
   endtask

   task automatic test_empty_and_oversized();
      write_dims(0, 2, 3);
      send_run();
      write_dims(3, 2, 0);
      send_run();
      write_dims(15, 0, 9);
      send_run();
   endtask

   task automatic test_unused_command();
      write_dims(1, 1, 1);
      send_item(CMD_UNUSED, 0, 0, 32'h1234_5678);
      send_item(CMD_UNUSED, 7, 7, 32'hFFFF_FFFF);
      send_run();
   endtask

   task automatic test_backpressure();
      write_dims(4, 2, 4);
      ensure_loaded();
      req_gap_max     = 0;
      rsp_hold_cycles = 300;
      send_run();
      repeat (3)
         send_item(CMD_CMD_SEL(), IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                   rand_value());
      ensure_loaded();
      send_run();
      req_gap_max = 9;
   endtask

   task automatic test_random_phases();
      int start;
      start = accepted_items;
      while (accepted_items - start < RANDOM_ITEMS) begin
         req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 9;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
         write_dims(rand_dim(), rand_dim(), rand_dim());
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 4))
               send_item(CMD_CMD_SEL(), IDX_W'($urandom_range(0, 7)),
                         IDX_W'($urandom_range(0, 7)), rand_value());
            if ($urandom_range(0, 5) == 0)
               send_item(CMD_UNUSED, IDX_W'($urandom_range(0, 7)),
                         IDX_W'($urandom_range(0, 7)), $urandom);
            ensure_loaded();
            send_run();
         end
      end
   endtask

   initial begin : rsp_driver
      int gap;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = $urandom_range(0, rsp_stall_max);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid && rsp_hold_cycles == 0);
      end
   end

   always @(posedge clock) begin : product_check
      product_type       want;
      logic [IDX_W-1:0]  got_row;
      logic [IDX_W-1:0]  got_col;
      logic [PROD_W-1:0] got_value;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_row   = rsp_tdata[2:0];
         got_col   = rsp_tdata[5:3];
         got_value = rsp_tdata[69:6];
         if (pending_products.size() == 0) begin
            report_mismatch($sformatf("unexpected item row %0d col %0d value %h",
                                      got_row, got_col, got_value));
         end else begin
            want = pending_products.pop_front();
            if (got_row !== want.row)
               report_mismatch($sformatf("out_row %0d, want %0d", got_row, want.row));
            if (got_col !== want.col)
               report_mismatch($sformatf("out_col %0d, want %0d", got_col, want.col));
            if (got_value !== want.value)
               report_mismatch($sformatf("product [%0d][%0d] %h, want %h",
                                         want.row, want.col, got_value, want.value));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("tlast %b at [%0d][%0d], want %b",
                                         rsp_tlast, want.row, want.col, want.last));
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_ROWS;
      csr_data   <= '0;
      cfg_rows      = RESET_DIM;
      cfg_inner     = RESET_DIM;
      cfg_cols      = RESET_DIM;
      req_gap_max   = 9;
      rsp_stall_max = 9;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_single_element();
      test_saturation();
      test_empty_and_oversized();
      test_unused_command();
      test_backpressure();
      test_random_phases();

      wait_drained();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
